/* hw/rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

	// Payload widths of the channels, the screen cell and the configuration port
	localparam int OP_W       = 2;
	localparam int CHAR_W     = 8;
	localparam int POS_W      = 11;
	localparam int ATTR_W     = 8;
	localparam int NIBBLE_W   = 4;
	localparam int CELL_W     = CHAR_W + ATTR_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// Default screen geometry
	localparam int DEF_ROWS    = 25;
	localparam int DEF_COLUMNS = 80;

	// Character and attribute constants
	localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]   BLANK_CHAR   = 8'h00;
	localparam logic [ATTR_W-1:0]   RESET_ATTR   = 8'h02;
	localparam logic [NIBBLE_W-1:0] RESET_FG     = 4'h2;
	localparam logic [NIBBLE_W-1:0] RESET_BG     = 4'h0;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

	// Request operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUT        = 2'd0,
		OP_CLEAR      = 2'd1,
		OP_SET_CURSOR = 2'd2,
		OP_READ_CELL  = 2'd3
	} tcw_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_NEWLINE,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} tcw_state_t;

endpackage

/* hw/rtl/tcw_if.sv */
// Request and response channel interfaces of the text console writer.
// Depends on tcw_pkg for payload widths.
interface tcw_req_if;
	import tcw_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [CHAR_W-1:0]   char_code;
	logic [POS_W-1:0]    position;
	logic                end_of_text;

	modport source (output valid, operation, char_code, position, end_of_text, input ready);
	modport sink   (input valid, operation, char_code, position, end_of_text, output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;

	logic                valid;
	logic                ready;
	logic [POS_W-1:0]    cursor;
	logic [CHAR_W-1:0]   cell_char;
	logic [ATTR_W-1:0]   cell_attr;

	modport source (output valid, cursor, cell_char, cell_attr, input ready);
	modport sink   (input valid, cursor, cell_char, cell_attr, output ready);
endinterface

/* hw/rtl/tcw_screen_ram.sv */
// Screen store: one character and one attribute byte per cell.
// One write and one registered read per cycle. Depends on tcw_pkg.
module tcw_screen_ram #(
	parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem_q [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/text_console_writer.sv */
// Character-cell text console writer. A request is accepted in the idle
// state and its response is loaded into the output register in the done
// state: put of an ordinary character, set cursor and read cell go straight
// from idle to done; a newline searches for the row start with one
// add-and-compare per row on a shared adder; a newline on the last row or a
// put of the final cell scrolls, which walks the whole screen store through
// its single write port; clear fills the whole store. After reset a clearing
// pass initializes the store before the first request is taken;
// configuration writes are accepted at all times. A request may be accepted
// while the previous response still waits in the output register.
module text_console_writer #(
	parameter int ROWS    = tcw_pkg::DEF_ROWS,
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tcw_req_if.sink                       req,
	tcw_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = AW + 1;
	localparam int PW    = (POS_W > CW) ? POS_W : CW;

	localparam logic [CW-1:0] CELLS_C    = CW'(CELLS);
	localparam logic [CW-1:0] LAST_C     = CW'(CELLS - 1);
	localparam logic [CW-1:0] COLS_C     = CW'(COLUMNS);
	localparam logic [CW-1:0] SCROLL_N   = CW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] LAST_ROW_A = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] LAST_A     = AW'(CELLS - 1);

	tcw_state_t state_q, state_d;

	logic [NIBBLE_W-1:0] fg_q, bg_q;
	logic [AW-1:0]       cursor_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       base_q;
	logic                rd_sel_q;

	logic                rsp_valid_q;
	logic [POS_W-1:0]    rsp_cursor_q;
	logic [CHAR_W-1:0]   rsp_char_q;
	logic [ATTR_W-1:0]   rsp_attr_q;

	// RAM port controls
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [CELL_W-1:0]   mem_wdata, mem_rdata;

	// Register loads
	logic                cursor_ld, idx_ld, base_ld, rd_sel_ld, rsp_ld;
	logic [AW-1:0]       cursor_d;
	logic [CW-1:0]       idx_d, base_d;

	// Request decode
	logic                accept;
	tcw_op_t             op;
	logic                is_newline;
	logic                pos_ok;
	logic [AW-1:0]       pos_a;
	logic [ATTR_W-1:0]   cur_attr;
	logic [CW-1:0]       put_next;
	logic                out_free;

	// Shared adder: row-start search and scroll read address
	logic [CW-1:0]       add_a, add_sum;
	logic                scroll_rd;

	assign accept     = req.valid && req.ready;
	assign op         = tcw_op_t'(req.operation);
	assign is_newline = (req.char_code == NEWLINE_CODE);
	assign pos_ok     = (PW'(req.position) < PW'(CELLS));
	assign pos_a      = AW'(req.position);
	assign cur_attr   = {bg_q, fg_q};
	assign put_next   = CW'(cursor_q) + CW'(1);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign add_a      = (state_q == ST_SCROLL) ? idx_q : base_q;
	assign add_sum    = add_a + COLS_C;
	assign scroll_rd  = (idx_q < SCROLL_N);

	assign req.ready  = (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (idx_q == LAST_C) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					case (op)
						OP_PUT: begin
							if (is_newline)            state_d = ST_NEWLINE;
							else if (put_next == CELLS_C) state_d = ST_SCROLL;
							else                       state_d = ST_DONE;
						end
						OP_CLEAR: state_d = ST_FILL;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_NEWLINE: begin
				if (add_sum > CW'(cursor_q)) begin
					state_d = (add_sum == CELLS_C) ? ST_SCROLL : ST_DONE;
				end
			end
			ST_SCROLL: begin
				if (idx_q == SCROLL_N) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (idx_q == LAST_C) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Datapath controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = {cur_attr, BLANK_CHAR};
		mem_re    = 1'b0;
		mem_raddr = pos_a;
		cursor_ld = 1'b0;
		cursor_d  = cursor_q;
		idx_ld    = 1'b0;
		idx_d     = idx_q + CW'(1);
		base_ld   = 1'b0;
		base_d    = add_sum;
		rd_sel_ld = 1'b0;
		rsp_ld    = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {RESET_ATTR, BLANK_CHAR};
				idx_ld    = 1'b1;
			end
			ST_IDLE: begin
				if (accept) begin
					rd_sel_ld = 1'b1;
					idx_ld    = 1'b1;
					idx_d     = '0;
					case (op)
						OP_PUT: begin
							if (is_newline) begin
								base_ld = 1'b1;
								base_d  = '0;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cursor_q;
								mem_wdata = {cur_attr, req.char_code};
								cursor_ld = 1'b1;
								cursor_d  = (put_next == CELLS_C) ? LAST_ROW_A
								                                  : put_next[AW-1:0];
							end
						end
						OP_CLEAR: begin
							cursor_ld = 1'b1;
							cursor_d  = '0;
						end
						OP_SET_CURSOR: begin
							cursor_ld = 1'b1;
							cursor_d  = pos_ok ? pos_a : LAST_A;
						end
						OP_READ_CELL: begin
							mem_re = pos_ok;
						end
						default: ;
					endcase
				end
			end
			ST_NEWLINE: begin
				if (add_sum > CW'(cursor_q)) begin
					cursor_ld = 1'b1;
					cursor_d  = (add_sum == CELLS_C) ? LAST_ROW_A : add_sum[AW-1:0];
				end else begin
					base_ld = 1'b1;
				end
			end
			ST_SCROLL: begin
				// read the cell one row below, write the one fetched last cycle
				mem_re    = scroll_rd;
				mem_raddr = add_sum[AW-1:0];
				mem_we    = (idx_q != '0);
				mem_waddr = AW'(idx_q - CW'(1));
				mem_wdata = {cur_attr, mem_rdata[CHAR_W-1:0]};
				idx_ld    = scroll_rd;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				idx_ld = 1'b1;
			end
			ST_DONE: begin
				rsp_ld = out_free;
			end
			default: ;
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			idx_q       <= '0;
			cursor_q    <= '0;
			fg_q        <= RESET_FG;
			bg_q        <= RESET_BG;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (idx_ld)    idx_q    <= idx_d;
			if (cursor_ld) cursor_q <= cursor_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FOREGROUND: fg_q <= cfg_wdata;
					CFG_BACKGROUND: bg_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (rsp_ld)         rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (base_ld)   base_q   <= base_d;
		if (rd_sel_ld) rd_sel_q <= (op == OP_READ_CELL) && pos_ok;
		if (rsp_ld) begin
			rsp_cursor_q <= POS_W'(cursor_q);
			rsp_char_q   <= rd_sel_q ? mem_rdata[CHAR_W-1:0] : BLANK_CHAR;
			rsp_attr_q   <= rd_sel_q ? mem_rdata[CELL_W-1:CHAR_W] : '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.cursor    = rsp_cursor_q;
	assign rsp.cell_char = rsp_char_q;
	assign rsp.cell_attr = rsp_attr_q;

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* hw/rtl/tcw_checker.sv */
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and on the top-level port names.
module tcw_checker #(
	parameter int ROWS    = tcw_pkg::DEF_ROWS,
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic [tcw_pkg::OP_W-1:0]   req_operation,
	input logic [tcw_pkg::POS_W-1:0]  req_position,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [tcw_pkg::POS_W-1:0]  rsp_cursor,
	input logic [tcw_pkg::CHAR_W-1:0] rsp_cell_char,
	input logic [tcw_pkg::ATTR_W-1:0] rsp_cell_attr
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int PW    = (POS_W > 16) ? POS_W : 16;
	localparam bit FITS  = (CELLS <= (1 << POS_W));

	logic [OP_W-1:0]  last_op_q;
	logic [POS_W-1:0] last_pos_q;
	logic             held_q;
	logic             fresh;

	// Remember the most recent request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_op_q  <= OP_PUT;
			last_pos_q <= '0;
		end else if (req_valid && req_ready) begin
			last_op_q  <= req_operation;
			last_pos_q <= req_position;
		end
	end

	// Response was stalled in the previous cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else begin
			held_q <= rsp_valid && !rsp_ready;
		end
	end

	// A newly loaded response belongs to the most recent request
	assign fresh = rsp_valid && !held_q;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor)
			&& $stable(rsp_cell_char) && $stable(rsp_cell_attr))
		else $error("response changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// cursor stays on screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && FITS |-> PW'(rsp_cursor) < PW'(CELLS))
		else $error("cursor beyond last cell");

	// only a read returns cell contents
	a_zero_cell: assert property (@(posedge clk) disable iff (!arst_n)
		fresh && (last_op_q != OP_READ_CELL) |-> (rsp_cell_char == '0) && (rsp_cell_attr == '0))
		else $error("cell data on a non-read response");

	// set cursor lands on the requested cell
	a_set_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		fresh && FITS && (last_op_q == OP_SET_CURSOR) && (PW'(last_pos_q) < PW'(CELLS))
			|-> rsp_cursor == last_pos_q)
		else $error("set cursor gave wrong position");

endmodule

bind text_console_writer tcw_checker #(
	.ROWS    (ROWS),
	.COLUMNS (COLUMNS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_operation (req.operation),
	.req_position  (req.position),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_cursor    (rsp.cursor),
	.rsp_cell_char (rsp.cell_char),
	.rsp_cell_attr (rsp.cell_attr)
);
